// ----- hdl/binary_loss_tomography_cover_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef BINARY_LOSS_TOMOGRAPHY_COVER_UNIT_MACROS_SVH
`define BINARY_LOSS_TOMOGRAPHY_COVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLT_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("blt check failed");

// The consequent must hold in the cycle after the antecedent.
`define BLT_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("blt check failed");

`endif

// ----- hdl/blt_pkg.sv -----
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants of the loss tomography cover unit.
// ----------------------------------------------------------------------------
package blt_pkg;

   localparam int LINKS_W = 64;
   localparam int HOPS_W  = 7;
   localparam int RATE_W  = 17;
   localparam int REQ_W   = 88;
   localparam int RSP_W   = 72;

   localparam logic [RATE_W-1:0] ONE_Q16           = 17'd65536;
   localparam logic [RATE_W-1:0] GOOD_THRESH_RESET = 17'd64225;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic thr_init;
      logic thr_step;
      logic cls_init;
      logic cls_latch;
      logic dup_init;
      logic dup_end;
      logic cov_init;
      logic score_init;
      logic max_init;
      logic max_step;
      logic choose;
      logic clr_init;
      logic rd_en;
      logic dup_mode;
      logic score_mode;
      logic clr_mode;
      logic out_load;
   } blt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic thr_done;
      logic rd_good;
      logic any_left;
      logic cand_nz;
   } blt_stat_type;

endpackage

// ----- hdl/blt_datapath.sv -----
// ----------------------------------------------------------------------------
// blt_datapath
// Path memory, threshold multiplier, pending flags, link scores and masks.
// ----------------------------------------------------------------------------
module blt_datapath #(
   parameter int MAX_PATHS = 256,
   parameter int NUM_LINKS = 64,
   parameter int AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1,
   parameter int CW = $clog2(MAX_PATHS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  blt_pkg::blt_cmd_type            cmd,
   output blt_pkg::blt_stat_type           stat,
   input  logic [AW-1:0]                   cur_idx,
   input  logic [AW-1:0]                   rd_addr,
   output logic [CW-1:0]                   path_count,
   input  logic [blt_pkg::LINKS_W-1:0]     in_links,
   input  logic [blt_pkg::HOPS_W-1:0]      in_hops,
   input  logic [blt_pkg::RATE_W-1:0]      in_rate,
   input  logic                            csr_we,
   input  logic [blt_pkg::RATE_W-1:0]      csr_value,
   output logic [blt_pkg::RSP_W-1:0]       rsp_data
);
   import blt_pkg::*;

   localparam int SW = $clog2(MAX_PATHS + 1);

   logic [NUM_LINKS-1:0] mem_mask [MAX_PATHS];
   logic [RATE_W-1:0]    mem_rate [MAX_PATHS];

   logic [RATE_W-1:0]    thresh_ff, thresh_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [HOPS_W-1:0]    longest_ff, longest_in;
   logic [HOPS_W-1:0]    thr_k_ff, thr_k_in;
   logic [RATE_W-1:0]    t_ff, t_in;
   logic                 rd_vld_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic [NUM_LINKS-1:0] rd_mask_ff;
   logic [RATE_W-1:0]    rd_rate_ff;
   logic [NUM_LINKS-1:0] held_ff, held_in;
   logic                 dup_ff, dup_in;
   logic [MAX_PATHS-1:0] pend_ff, pend_in;
   logic                 left_ff, left_in;
   logic [NUM_LINKS-1:0] good_ff, good_in, bad_ff, bad_in;
   logic [NUM_LINKS-1:0] cand_ff, cand_in, failed_ff, failed_in;
   logic [NUM_LINKS-1:0] chosen;
   logic [NUM_LINKS-1:0] last_pick_ff, last_pick_in;
   logic [HOPS_W-1:0]    rounds_ff, rounds_in;
   logic [SW-1:0]        score_ff [NUM_LINKS];
   logic [SW-1:0]        score_in [NUM_LINKS];
   logic [SW-1:0]        best_ff, best_in;
   logic [RSP_W-1:0]     rsp_ff, rsp_in;
   logic [RATE_W-1:0]    g_clamp;
   logic [2*RATE_W-1:0]  prod;
   logic                 full;

   assign full     = (count_ff == CW'(MAX_PATHS));
   assign g_clamp  = (thresh_ff > ONE_Q16) ? ONE_Q16 : thresh_ff;
   assign prod     = t_ff * g_clamp;
   assign path_count = count_ff;
   assign rsp_data = rsp_ff;

   assign stat.thr_done = (thr_k_ff == longest_ff);
   assign stat.rd_good  = (rd_rate_ff >= t_ff);
   assign stat.any_left = left_ff;
   assign stat.cand_nz  = |cand_ff;

   // Links picked in the latest round; held until the clearing pass is over.
   assign last_pick_in = cmd.choose ? chosen : last_pick_ff;

   always_comb begin
      for (int l = 0; l < NUM_LINKS; l++) begin
         chosen[l] = cand_ff[l] && (score_ff[l] == best_ff);
      end
   end

   always_comb begin
      thresh_in  = csr_we ? csr_value : thresh_ff;
      count_in   = count_ff;
      longest_in = longest_ff;
      thr_k_in   = thr_k_ff;
      t_in       = t_ff;
      held_in    = held_ff;
      dup_in     = dup_ff;
      pend_in    = pend_ff;
      left_in    = left_ff;
      good_in    = good_ff;
      bad_in     = bad_ff;
      cand_in    = cand_ff;
      failed_in  = failed_ff;
      rounds_in  = rounds_ff;
      best_in    = best_ff;
      rsp_in     = rsp_ff;
      score_in   = score_ff;

      if (cmd.load && !full) begin
         count_in = count_ff + CW'(1);
         if (in_hops > longest_ff) begin
            longest_in = in_hops;
         end
      end
      if (cmd.thr_init) begin
         t_in     = ONE_Q16;
         thr_k_in = '0;
      end
      if (cmd.thr_step) begin
         t_in     = prod[RATE_W+15:16];
         thr_k_in = thr_k_ff + HOPS_W'(1);
      end
      if (cmd.cls_init) begin
         good_in = '0;
         bad_in  = '0;
         left_in = 1'b0;
      end
      if (cmd.cls_latch) begin
         held_in = rd_mask_ff;
         if (rd_rate_ff >= t_ff) begin
            good_in          = good_ff | rd_mask_ff;
            pend_in[cur_idx] = 1'b0;
         end else begin
            bad_in = bad_ff | rd_mask_ff;
         end
      end
      if (cmd.dup_init) begin
         dup_in = 1'b0;
      end
      if (rd_vld_ff && cmd.dup_mode && pend_ff[rd_idx_ff] && (rd_mask_ff == held_ff)) begin
         dup_in = 1'b1;
      end
      if (cmd.dup_end) begin
         pend_in[cur_idx] = !dup_ff;
         if (!dup_ff) begin
            left_in = 1'b1;
         end
      end
      if (cmd.cov_init) begin
         cand_in   = bad_ff & ~good_ff;
         failed_in = '0;
         rounds_in = '0;
      end
      if (cmd.score_init) begin
         for (int l = 0; l < NUM_LINKS; l++) begin
            score_in[l] = '0;
         end
      end
      if (rd_vld_ff && cmd.score_mode && pend_ff[rd_idx_ff]) begin
         for (int l = 0; l < NUM_LINKS; l++) begin
            if (rd_mask_ff[l] && cand_ff[l]) begin
               score_in[l] = score_ff[l] + SW'(1);
            end
         end
      end
      if (cmd.max_init) begin
         best_in = '0;
      end
      // The score row rotates once around while the running maximum looks at lane zero.
      if (cmd.max_step) begin
         if (score_ff[0] > best_ff) begin
            best_in = score_ff[0];
         end
         for (int l = 0; l < NUM_LINKS; l++) begin
            score_in[l] = score_ff[(l == NUM_LINKS - 1) ? 0 : l + 1];
         end
      end
      if (cmd.choose) begin
         failed_in = failed_ff | chosen;
         cand_in   = cand_ff & ~chosen;
         rounds_in = rounds_ff + HOPS_W'(1);
      end
      if (cmd.clr_init) begin
         left_in = 1'b0;
      end
      if (rd_vld_ff && cmd.clr_mode && pend_ff[rd_idx_ff]) begin
         if (|(rd_mask_ff & failed_ff & ~cand_ff & last_pick_ff)) begin
            pend_in[rd_idx_ff] = 1'b0;
         end else begin
            left_in = 1'b1;
         end
      end
      if (cmd.out_load) begin
         rsp_in     = {rounds_ff, left_ff, LINKS_W'(failed_ff)};
         count_in   = '0;
         longest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem_mask[count_ff[AW-1:0]] <= in_links[NUM_LINKS-1:0];
         mem_rate[count_ff[AW-1:0]] <= in_rate;
      end
   end

   always_ff @(posedge clock) begin
      rd_mask_ff <= mem_mask[rd_addr];
      rd_rate_ff <= mem_rate[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= GOOD_THRESH_RESET;
         count_ff   <= '0;
         longest_ff <= '0;
         rd_vld_ff  <= 1'b0;
         pend_ff    <= '0;
         left_ff    <= 1'b0;
         cand_ff    <= '0;
         failed_ff  <= '0;
         rounds_ff  <= '0;
      end else begin
         thresh_ff  <= thresh_in;
         count_ff   <= count_in;
         longest_ff <= longest_in;
         rd_vld_ff  <= cmd.rd_en;
         pend_ff    <= pend_in;
         left_ff    <= left_in;
         cand_ff    <= cand_in;
         failed_ff  <= failed_in;
         rounds_ff  <= rounds_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_k_ff     <= thr_k_in;
      t_ff         <= t_in;
      held_ff      <= held_in;
      dup_ff       <= dup_in;
      good_ff      <= good_in;
      bad_ff       <= bad_in;
      best_ff      <= best_in;
      rsp_ff       <= rsp_in;
      score_ff     <= score_in;
      last_pick_ff <= last_pick_in;
   end

endmodule

// ----- hdl/blt_controller.sv -----
// ----------------------------------------------------------------------------
// blt_controller
// Sequencer for loading, threshold, classification and greedy cover rounds.
// ----------------------------------------------------------------------------
module blt_controller #(
   parameter int MAX_PATHS = 256,
   parameter int NUM_LINKS = 64,
   parameter int AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1,
   parameter int CW = $clog2(MAX_PATHS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output blt_pkg::blt_cmd_type  cmd,
   input  blt_pkg::blt_stat_type stat,
   output logic [AW-1:0]         cur_idx,
   output logic [AW-1:0]         rd_addr,
   input  logic [CW-1:0]         path_count
);
   import blt_pkg::*;

   localparam int LW = $clog2(NUM_LINKS + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_THR     = 4'd1;
   localparam logic [3:0] S_CLS_RD  = 4'd2;
   localparam logic [3:0] S_CLS_EV  = 4'd3;
   localparam logic [3:0] S_DUP     = 4'd4;
   localparam logic [3:0] S_DUP_END = 4'd5;
   localparam logic [3:0] S_COV     = 4'd6;
   localparam logic [3:0] S_CHECK   = 4'd7;
   localparam logic [3:0] S_SCORE   = 4'd8;
   localparam logic [3:0] S_MAX     = 4'd9;
   localparam logic [3:0] S_CHOOSE  = 4'd10;
   localparam logic [3:0] S_CLEAR   = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [LW-1:0] l_ff, l_in;
   logic          rsp_vld_ff, rsp_vld_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign cur_idx    = i_ff[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      l_in       = l_ff;
      rsp_vld_in = (rsp_vld_ff && !rsp_tready);
      cmd        = '0;
      rd_addr    = j_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.thr_init = 1'b1;
                  state_in     = S_THR;
               end
            end
         end
         S_THR: begin
            if (!stat.thr_done) begin
               cmd.thr_step = 1'b1;
            end else begin
               cmd.cls_init = 1'b1;
               i_in         = '0;
               state_in     = S_CLS_RD;
            end
         end
         S_CLS_RD: begin
            rd_addr = i_ff[AW-1:0];
            if (i_ff == path_count) begin
               state_in = S_COV;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CLS_EV;
            end
         end
         S_CLS_EV: begin
            cmd.cls_latch = 1'b1;
            if (stat.rd_good) begin
               i_in     = i_ff + CW'(1);
               state_in = S_CLS_RD;
            end else begin
               cmd.dup_init = 1'b1;
               j_in         = '0;
               state_in     = S_DUP;
            end
         end
         // Compare the held bad mask against every earlier first-of-its-mask path.
         S_DUP: begin
            cmd.dup_mode = 1'b1;
            if (j_ff != i_ff) begin
               cmd.rd_en = 1'b1;
               j_in      = j_ff + CW'(1);
            end else begin
               state_in = S_DUP_END;
            end
         end
         S_DUP_END: begin
            cmd.dup_end = 1'b1;
            i_in        = i_ff + CW'(1);
            state_in    = S_CLS_RD;
         end
         S_COV: begin
            cmd.cov_init = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (stat.any_left && stat.cand_nz) begin
               cmd.score_init = 1'b1;
               j_in           = '0;
               state_in       = S_SCORE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCORE: begin
            cmd.score_mode = 1'b1;
            if (j_ff != path_count) begin
               cmd.rd_en = 1'b1;
               j_in      = j_ff + CW'(1);
            end else begin
               cmd.max_init = 1'b1;
               l_in         = '0;
               state_in     = S_MAX;
            end
         end
         S_MAX: begin
            if (l_ff != LW'(NUM_LINKS)) begin
               cmd.max_step = 1'b1;
               l_in         = l_ff + LW'(1);
            end else begin
               state_in = S_CHOOSE;
            end
         end
         S_CHOOSE: begin
            cmd.choose   = 1'b1;
            cmd.clr_init = 1'b1;
            j_in         = '0;
            state_in     = S_CLEAR;
         end
         S_CLEAR: begin
            cmd.clr_mode = 1'b1;
            if (j_ff != path_count) begin
               cmd.rd_en = 1'b1;
               j_in      = j_ff + CW'(1);
            end else begin
               state_in = S_CHECK;
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_vld_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_vld_ff <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         l_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         l_ff       <= l_in;
      end
   end

endmodule

// ----- hdl/binary_loss_tomography_cover_unit.sv -----
// ----------------------------------------------------------------------------
// binary_loss_tomography_cover_unit
// Collects measured paths and finds failed links by greedy set cover.
//
//   channel  direction  contents
//   req      in         one measured path per transaction, tlast ends the set
//   rsp      out        failed link mask, unexplained flag, round count
//   csr      in         good link threshold, Q1.16
//
// A path that is not the last is taken in the cycle it is offered while the
// unit is idle. After the last path the unit runs the threshold multiplier,
// scans each bad path against the earlier paths of the set through one
// memory port, and then runs the greedy cover rounds.
// Reset is synchronous and needs no clearing pass.
// A stalled result stays in its register; the next set loads meanwhile.
// ----------------------------------------------------------------------------
module binary_loss_tomography_cover_unit #(
   parameter int MAX_PATHS = 256,
   parameter int NUM_LINKS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [blt_pkg::REQ_W-1:0]   req_tdata,  // path_links, hop_count, path_rate
   input  logic                        req_tlast,  // last_path
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [blt_pkg::RSP_W-1:0]   rsp_tdata,  // failed_links, unexplained, rounds
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [blt_pkg::RATE_W-1:0]  csr_data    // good_thresh
);
   import blt_pkg::*;

   localparam int AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
   localparam int CW = $clog2(MAX_PATHS + 1);

   blt_cmd_type   cmd;
   blt_stat_type  stat;
   logic [AW-1:0] cur_idx, rd_addr;
   logic [CW-1:0] path_count;

   assign csr_ready = 1'b1;

   blt_controller #(
      .MAX_PATHS(MAX_PATHS),
      .NUM_LINKS(NUM_LINKS),
      .AW(AW),
      .CW(CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat),
      .cur_idx    (cur_idx),
      .rd_addr    (rd_addr),
      .path_count (path_count)
   );

   blt_datapath #(
      .MAX_PATHS(MAX_PATHS),
      .NUM_LINKS(NUM_LINKS),
      .AW(AW),
      .CW(CW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cur_idx    (cur_idx),
      .rd_addr    (rd_addr),
      .path_count (path_count),
      .in_links   (req_tdata[LINKS_W-1:0]),
      .in_hops    (req_tdata[LINKS_W+HOPS_W-1:LINKS_W]),
      .in_rate    (req_tdata[REQ_W-1:LINKS_W+HOPS_W]),
      .csr_we     (csr_valid),
      .csr_value  (csr_data),
      .rsp_data   (rsp_tdata)
   );

endmodule

// ----- hdl/blt_checker.sv -----
// ----------------------------------------------------------------------------
// blt_checker
// Port-level checks of the loss tomography cover unit.
// ----------------------------------------------------------------------------
`include "binary_loss_tomography_cover_unit_macros.svh"

module blt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [87:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [16:0] csr_data
);

   // A stalled result must hold.
   `BLT_ASSERT_NEXT(rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The last path of a set starts the cover work, so no path is taken next.
   `BLT_ASSERT_NEXT(busy_after_last, req_tvalid && req_tready && req_tlast, !req_tready)

   // Each round removes at least one link, so rounds never exceed the link count.
   `BLT_ASSERT_NOW(rounds_bound, rsp_tvalid, rsp_tdata[71:65] <= 7'd64)

endmodule

bind binary_loss_tomography_cover_unit blt_checker u_blt_checker (.*);
